@@ design/grid_line_crossing_tracer_defines.svh @@
// Assertion macros used by the crossing tracer top level.
`ifndef GRID_LINE_CROSSING_TRACER_DEFINES_SVH
`define GRID_LINE_CROSSING_TRACER_DEFINES_SVH
`ifndef SYNTHESIS
`define GLCT_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");
`define GLCT_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
	else $error("assertion failed");
`else
`define GLCT_ASSERT_IMPL(label, clk, rst_n, prop)
`define GLCT_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

@@ design/glct_pkg.sv @@
// Package with widths, constants and shared types of the crossing tracer.
package glct_pkg;
	localparam int CoordW = 13;
	localparam int FracBits = 8;
	localparam int GridTiles = 32;
	localparam int KW = 7;
	localparam int DW = 14;
	localparam int ProdW = 28;
	localparam int QW = CoordW;
	localparam logic [CoordW-1:0] HalfUnit = CoordW'(1 << (FracBits - 1));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	typedef struct packed {
		logic [CoordW-1:0] ox;
		logic [CoordW-1:0] oy;
		logic [CoordW-1:0] ex;
		logic [CoordW-1:0] ey;
		logic signed [DW-1:0] ddx;
		logic signed [DW-1:0] ddy;
		logic sx_pos;
		logic sx_neg;
		logic sy_pos;
		logic sy_neg;
	} seg_t;

	typedef struct packed {
		logic [CoordW-1:0] px;
		logic [CoordW-1:0] py;
		logic has_point;
		logic last;
	} pt_t;

	typedef struct packed {
		logic tx;
		logic ty;
		logic last;
		logic none;
		logic neg;
		logic [CoordW-1:0] lx;
		logic [CoordW-1:0] ly;
		logic [CoordW-1:0] base;
		logic [CoordW-1:0] dv;
	} div_ctl_t;

	function automatic logic [KW+FracBits:0] line_pos(input logic signed [KW:0] k);
		line_pos = {1'b0, k[KW-1:0], HalfUnit[FracBits-1:0]};
	endfunction
endpackage

@@ design/grid_line_crossing_tracer.sv @@
// Top level of the grid line crossing tracer.
// Channel  Dir  Contents
// s_axis   in   tdata: origin_x, origin_y, dest_x, dest_y (13 bits each, low first)
// m_axis   out  tdata: point_x, point_y; tlast: last; tuser: has_point
// The line walker takes a segment and then issues one result per cycle while the output
// is not stalled, at least one and at most 64; it takes no new segment until its last result.
// Each result passes five pipeline stages.
// Reset clears the walker state and the stage valid bits.
// A stalled output holds the whole pipeline and a walker in its run state without loss.
`include "grid_line_crossing_tracer_defines.svh"
module grid_line_crossing_tracer (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [55:0] s_axis_tdata, // origin_x, origin_y, dest_x, dest_y
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // point_x, point_y
	output logic m_axis_tlast,
	output logic m_axis_tuser // has_point
);
	glct_pkg::seg_t in_seg, op_seg;
	logic stall, op_valid, op_tx, op_ty, op_last, op_none, res_valid;
	logic signed [glct_pkg::KW:0] op_kx, op_ky;
	glct_pkg::pt_t res_pt;
	logic [12:0] ox, oy, ex, ey;

	always_comb begin
		ox = s_axis_tdata[12:0];
		oy = s_axis_tdata[25:13];
		ex = s_axis_tdata[38:26];
		ey = s_axis_tdata[51:39];
		in_seg.ox = ox;
		in_seg.oy = oy;
		in_seg.ex = ex;
		in_seg.ey = ey;
		in_seg.ddx = $signed({1'b0, ex}) - $signed({1'b0, ox});
		in_seg.ddy = $signed({1'b0, ey}) - $signed({1'b0, oy});
		in_seg.sx_pos = ex > ox;
		in_seg.sx_neg = ex < ox;
		in_seg.sy_pos = ey > oy;
		in_seg.sy_neg = ey < oy;
	end

	assign stall = res_valid && !m_axis_tready;

	glct_seq u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_seg(in_seg), .stall(stall), .op_valid(op_valid), .op_tx(op_tx),
		.op_ty(op_ty), .op_last(op_last), .op_none(op_none), .op_kx(op_kx),
		.op_ky(op_ky), .op_seg(op_seg)
	);

	glct_prop u_prop (
		.clk(clk), .arst_n(arst_n), .stall(stall), .op_valid(op_valid), .op_tx(op_tx),
		.op_ty(op_ty), .op_last(op_last), .op_none(op_none), .op_kx(op_kx),
		.op_ky(op_ky), .op_seg(op_seg), .res_valid(res_valid), .res_pt(res_pt)
	);

	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata = {6'd0, res_pt.py, res_pt.px};
	assign m_axis_tlast = res_pt.last;
	assign m_axis_tuser = res_pt.has_point;

	`GLCT_ASSERT_IMPL(a_empty_is_last, clk, arst_n, !m_axis_tvalid || m_axis_tuser || m_axis_tlast)
	`GLCT_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

@@ design/glct_seq.sv @@
// Sequencer that walks the grid lines of one segment and issues one crossing a cycle while not stalled.
module glct_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  glct_pkg::seg_t in_seg,
	input  logic stall,
	output logic op_valid,
	output logic op_tx,
	output logic op_ty,
	output logic op_last,
	output logic op_none,
	output logic signed [glct_pkg::KW:0] op_kx,
	output logic signed [glct_pkg::KW:0] op_ky,
	output glct_pkg::seg_t op_seg
);
	localparam int DW = glct_pkg::DW;

	glct_pkg::seq_state_t state_q, state_d;
	glct_pkg::seg_t seg_q;
	logic signed [glct_pkg::KW:0] kx_q, ky_q, kx_d, ky_d;
	logic hx, hy, tx, ty, hx_n, hy_n;
	logic signed [glct_pkg::KW:0] kx_n, ky_n, kx0, ky0;
	logic [glct_pkg::ProdW-1:0] ax, ay;
	logic [glct_pkg::DW-1:0] adx, ady, lxo, lyo;

	function automatic logic signed [glct_pkg::KW:0] first_k(
			input logic [glct_pkg::CoordW-1:0] p, input logic pos);
		logic [glct_pkg::CoordW:0] t;
		t = pos ? ({1'b0, p} + {1'b0, glct_pkg::HalfUnit})
			: ({1'b0, p} - {1'b0, glct_pkg::HalfUnit} - 14'd1);
		first_k = (!pos && p < glct_pkg::HalfUnit + 13'd1) ? -8'sd1
			: $signed({2'b00, t[glct_pkg::CoordW:glct_pkg::FracBits]});
	endfunction

	function automatic logic ok(input logic signed [glct_pkg::KW:0] k, input logic p,
			input logic n, input logic [glct_pkg::CoordW-1:0] e);
		logic [glct_pkg::KW+glct_pkg::FracBits:0] lp;
		lp = glct_pkg::line_pos(k);
		ok = (p || n) && k >= 0 && k < glct_pkg::GridTiles
			&& (p ? lp < {3'b000, e} : lp > {3'b000, e});
	endfunction

	always_comb begin
		hx = ok(kx_q, seg_q.sx_pos, seg_q.sx_neg, seg_q.ex);
		hy = ok(ky_q, seg_q.sy_pos, seg_q.sy_neg, seg_q.ey);
		adx = seg_q.ddx < 0 ? DW'(-seg_q.ddx) : DW'(seg_q.ddx);
		ady = seg_q.ddy < 0 ? DW'(-seg_q.ddy) : DW'(seg_q.ddy);
		lxo = seg_q.sx_pos ? DW'(glct_pkg::line_pos(kx_q)) - DW'(seg_q.ox)
			: DW'(seg_q.ox) - DW'(glct_pkg::line_pos(kx_q));
		lyo = seg_q.sy_pos ? DW'(glct_pkg::line_pos(ky_q)) - DW'(seg_q.oy)
			: DW'(seg_q.oy) - DW'(glct_pkg::line_pos(ky_q));
		ax = lxo * ady;
		ay = lyo * adx;
		tx = hx && (!hy || ax <= ay);
		ty = hy && (!hx || ay <= ax);
		kx_n = tx ? (seg_q.sx_pos ? kx_q + 8'sd1 : kx_q - 8'sd1) : kx_q;
		ky_n = ty ? (seg_q.sy_pos ? ky_q + 8'sd1 : ky_q - 8'sd1) : ky_q;
		hx_n = ok(kx_n, seg_q.sx_pos, seg_q.sx_neg, seg_q.ex);
		hy_n = ok(ky_n, seg_q.sy_pos, seg_q.sy_neg, seg_q.ey);
		kx0 = first_k(in_seg.ox, in_seg.sx_pos);
		ky0 = first_k(in_seg.oy, in_seg.sy_pos);
		state_d = state_q;
		kx_d = kx_q;
		ky_d = ky_q;
		in_ready = 1'b0;
		op_valid = 1'b0;
		op_none = 1'b0;
		op_last = 1'b0;
		case (state_q)
			glct_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = glct_pkg::ST_RUN;
					kx_d = kx0;
					ky_d = ky0;
				end
			end
			glct_pkg::ST_RUN: begin
				op_valid = 1'b1;
				op_none = !(hx || hy);
				op_last = op_none || !(hx_n || hy_n);
				if (!stall) begin
					kx_d = kx_n;
					ky_d = ky_n;
					if (op_last) state_d = glct_pkg::ST_IDLE;
				end
			end
			default: state_d = glct_pkg::ST_IDLE;
		endcase
	end

	assign op_tx = tx;
	assign op_ty = ty;
	assign op_kx = kx_q;
	assign op_ky = ky_q;
	assign op_seg = seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		kx_q <= kx_d;
		ky_q <= ky_d;
		if (in_ready && in_valid) seg_q <= in_seg;
	end
endmodule

@@ design/glct_prop.sv @@
// Pipeline that turns one line crossing into a rounded point over five stages.
module glct_prop (
	input  logic clk,
	input  logic arst_n,
	input  logic stall,
	input  logic op_valid,
	input  logic op_tx,
	input  logic op_ty,
	input  logic op_last,
	input  logic op_none,
	input  logic signed [glct_pkg::KW:0] op_kx,
	input  logic signed [glct_pkg::KW:0] op_ky,
	input  glct_pkg::seg_t op_seg,
	output logic res_valid,
	output glct_pkg::pt_t res_pt
);
	localparam int CW = glct_pkg::CoordW;
	localparam int QW = glct_pkg::QW;
	localparam int RW = 2 * glct_pkg::CoordW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	glct_pkg::div_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [RW-1:0] rem_s1, rem_s2, rem_s3, rem_s4;
	logic [QW-1:0] q_s2, q_s3, q_s4;
	glct_pkg::pt_t pt_s5;

	logic [CW-1:0] lxv, lyv, lxo, lyo, adx, ady;
	logic [RW-1:0] mx, my;
	logic [RW-1:0] r2, r3, r4;
	logic [QW-1:0] q2, q3, q4;
	logic [RW:0] step2, step3, step4;
	logic [CW:0] twice_r;
	logic up;
	logic [CW-1:0] mag, off_pt;

	function automatic logic [RW:0] div_bit(input logic [RW-1:0] r,
			input logic [RW-1:0] sd);
		if (r >= sd)
			div_bit = {1'b1, r - sd};
		else
			div_bit = {1'b0, r};
	endfunction

	// Stage 1: magnitude of the numerator, divisor and sign of the offset.
	always_comb begin
		lxv = CW'(glct_pkg::line_pos(op_kx));
		lyv = CW'(glct_pkg::line_pos(op_ky));
		lxo = op_seg.sx_pos ? lxv - op_seg.ox : op_seg.ox - lxv;
		lyo = op_seg.sy_pos ? lyv - op_seg.oy : op_seg.oy - lyv;
		adx = op_seg.ddx < 0 ? CW'(-op_seg.ddx) : CW'(op_seg.ddx);
		ady = op_seg.ddy < 0 ? CW'(-op_seg.ddy) : CW'(op_seg.ddy);
		mx = lyo * adx;
		my = lxo * ady;
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ctl_s1.tx <= op_tx;
			ctl_s1.ty <= op_ty;
			ctl_s1.last <= op_last;
			ctl_s1.none <= op_none;
			ctl_s1.lx <= lxv;
			ctl_s1.ly <= lyv;
			ctl_s1.base <= op_tx ? op_seg.oy : op_seg.ox;
			ctl_s1.neg <= op_tx ? (op_seg.ddy < 0) : (op_seg.ddx < 0);
			ctl_s1.dv <= op_tx ? adx : ady;
			rem_s1 <= op_tx ? my : mx;
		end
	end

	// Stages 2 to 4: restoring division, five quotient bits in stage 2 and four each in stages 3 and 4.
	always_comb begin
		r2 = rem_s1;
		q2 = '0;
		for (int i = QW - 1; i >= 8; i--) begin
			step2 = div_bit(r2, RW'(ctl_s1.dv) << i);
			r2 = step2[RW-1:0];
			q2[i] = step2[RW];
		end
	end

	always_comb begin
		r3 = rem_s2;
		q3 = q_s2;
		for (int i = 7; i >= 4; i--) begin
			step3 = div_bit(r3, RW'(ctl_s2.dv) << i);
			r3 = step3[RW-1:0];
			q3[i] = step3[RW];
		end
	end

	always_comb begin
		r4 = rem_s3;
		q4 = q_s3;
		for (int i = 3; i >= 0; i--) begin
			step4 = div_bit(r4, RW'(ctl_s3.dv) << i);
			r4 = step4[RW-1:0];
			q4[i] = step4[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ctl_s2 <= ctl_s1;
			rem_s2 <= r2;
			q_s2 <= q2;
			ctl_s3 <= ctl_s2;
			rem_s3 <= r3;
			q_s3 <= q3;
			ctl_s4 <= ctl_s3;
			rem_s4 <= r4;
			q_s4 <= q4;
		end
	end

	// Stage 5: round half up and add the offset to, or subtract it from, the origin coordinate by its sign.
	always_comb begin
		twice_r = {rem_s4[CW-1:0], 1'b0};
		up = ctl_s4.neg ? (twice_r > {1'b0, ctl_s4.dv}) : (twice_r >= {1'b0, ctl_s4.dv});
		mag = q_s4 + CW'(up);
		off_pt = ctl_s4.neg ? ctl_s4.base - mag : ctl_s4.base + mag;
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			pt_s5.has_point <= !ctl_s4.none;
			pt_s5.last <= ctl_s4.last;
			pt_s5.px <= ctl_s4.none ? '0 : (ctl_s4.tx ? ctl_s4.lx : off_pt);
			pt_s5.py <= ctl_s4.none ? '0 : (ctl_s4.ty ? ctl_s4.ly : off_pt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= op_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign res_valid = v_s5;
	assign res_pt = pt_s5;
endmodule
